>>> sv/mrps_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// max-removal priority store. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mrps_pkg;

    localparam int DEPTH  = 64;
    localparam int VAL_W  = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CAP_W  = 8;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_FIND   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(2);
    localparam logic [CAP_W-1:0] CAP_MIN_SHRINK = CAP_W'(4);

    typedef enum logic [2:0] {
        RES_NOP,
        RES_ADD,
        RES_FULL,
        RES_EMPTY,
        RES_NOT_FOUND,
        RES_FOUND,
        RES_REMOVED
    } res_kind_t;

    typedef struct packed {
        logic      capture;
        logic      scan;
        logic      shift_init;
        logic      shift;
        logic      finish;
        res_kind_t kind;
    } mrps_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       empty;
        logic       full;
        logic       find_hit;
        logic       pass_done;
    } mrps_stat_t;

endpackage

`default_nettype wire

>>> sv/max_removal_priority_store_top.sv
// Top level of the max-removal priority store: joins controller and datapath.
// Depends on mrps_pkg, mrps_ctrl and mrps_datapath.
//
// Usage:
//   A transaction is accepted at a rising edge with start high and busy low;
//   operation and value are sampled then. busy stays high until the result
//   has been shown. One result per transaction appears on status,
//   removed_value, found_index, entry_count and logical_capacity while done
//   is high, for exactly one cycle; the receiver cannot stall it.
//   Add, an unused code, remove on empty and find on empty finish at decode.
//   Find scans the entries from index 0 and stops at the first match or
//   after the last entry; remove scans all N stored entries for the maximum,
//   then shifts the entries above the index k taken out down by one.
//   The next transaction is accepted in the cycle after done at the earliest.
//   The pace is set by the single read port of the entry memory: one entry
//   per cycle on the maximum scan, then one per cycle on the shift-down.
//   Reset clears the count to zero and the capacity to two; entry contents
//   are not cleared, since only written entries are ever read.
`timescale 1ns / 1ps
`default_nettype none

module max_removal_priority_store_top (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              start,
    input  wire [1:0]                        operation,
    input  wire signed [mrps_pkg::VAL_W-1:0] value,
    output logic                             busy,
    output logic                             done,
    output logic [1:0]                       status,
    output logic signed [mrps_pkg::VAL_W-1:0] removed_value,
    output logic [mrps_pkg::ADDR_W-1:0]      found_index,
    output logic [mrps_pkg::CNT_W-1:0]       entry_count,
    output logic [mrps_pkg::CAP_W-1:0]       logical_capacity
);
    import mrps_pkg::*;

    mrps_cmd_t  cmd;
    mrps_stat_t st;

    mrps_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .st    (st),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    mrps_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .operation        (operation),
        .value            (value),
        .cmd              (cmd),
        .st               (st),
        .status           (status),
        .removed_value    (removed_value),
        .found_index      (found_index),
        .entry_count      (entry_count),
        .logical_capacity (logical_capacity)
    );

endmodule

`default_nettype wire

>>> sv/mrps_datapath.sv
// Datapath: entry memory, scan/shift pointers, count, capacity and result
// registers. Depends on mrps_pkg; driven by mrps_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module mrps_datapath (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire [1:0]                     operation,
    input  wire signed [mrps_pkg::VAL_W-1:0] value,
    input  mrps_pkg::mrps_cmd_t           cmd,
    output mrps_pkg::mrps_stat_t          st,
    output logic [1:0]                    status,
    output logic signed [mrps_pkg::VAL_W-1:0] removed_value,
    output logic [mrps_pkg::ADDR_W-1:0]   found_index,
    output logic [mrps_pkg::CNT_W-1:0]    entry_count,
    output logic [mrps_pkg::CAP_W-1:0]    logical_capacity
);
    import mrps_pkg::*;

    logic signed [VAL_W-1:0] mem [DEPTH];

    logic [1:0]              op_reg;
    logic signed [VAL_W-1:0] val_reg;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic                    rv_reg;
    logic [ADDR_W-1:0]       didx_reg;
    logic signed [VAL_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]       best_idx_reg;
    logic signed [VAL_W-1:0] best_val_reg;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CAP_W-1:0]        cap_reg, cap_next;

    logic                    rd_issue;
    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic signed [VAL_W-1:0] wr_data;
    logic                    add_commit;
    logic                    rem_commit;
    logic [CNT_W-1:0]        cnt_inc, cnt_dec;

    logic [1:0]              status_next;
    logic signed [VAL_W-1:0] removed_next;
    logic [ADDR_W-1:0]       found_next;

    assign rd_issue   = (cmd.scan || cmd.shift) && (idx_reg < count_reg);
    assign add_commit = cmd.finish && (cmd.kind == RES_ADD);
    assign rem_commit = cmd.finish && (cmd.kind == RES_REMOVED);
    assign wr_en      = add_commit || (cmd.shift && rv_reg);
    assign wr_addr    = add_commit ? count_reg[ADDR_W-1:0] : didx_reg - ADDR_W'(1);
    assign wr_data    = add_commit ? val_reg : rd_data_reg;
    assign cnt_inc    = count_reg + CNT_W'(1);
    assign cnt_dec    = count_reg - CNT_W'(1);

    assign st.op        = op_reg;
    assign st.empty     = (count_reg == '0);
    assign st.full      = (count_reg == CNT_W'(DEPTH));
    assign st.find_hit  = rv_reg && (rd_data_reg == val_reg);
    assign st.pass_done = !rv_reg && (idx_reg == count_reg);

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.capture)
        begin
            idx_next = '0;
        end
        else if (cmd.shift_init)
        begin
            idx_next = {1'b0, best_idx_reg} + CNT_W'(1);
        end
        else if (rd_issue)
        begin
            idx_next = idx_reg + CNT_W'(1);
        end
    end

    // Grow before the append, shrink after the take-out.
    always_comb
    begin
        count_next = count_reg;
        cap_next   = cap_reg;
        if (add_commit)
        begin
            count_next = cnt_inc;
            if ({1'b0, count_reg} == (cap_reg >> 1))
            begin
                cap_next = cap_reg << 1;
            end
        end
        else if (rem_commit)
        begin
            count_next = cnt_dec;
            if (({1'b0, cnt_dec} < (cap_reg >> 2)) && (cap_reg >= CAP_MIN_SHRINK))
            begin
                cap_next = cap_reg >> 1;
            end
        end
    end

    always_comb
    begin
        status_next  = ST_OK;
        removed_next = '0;
        found_next   = '0;
        case (cmd.kind)
            RES_FULL:      status_next  = ST_FULL;
            RES_EMPTY:     status_next  = ST_EMPTY;
            RES_NOT_FOUND: status_next  = ST_NOT_FOUND;
            RES_FOUND:     found_next   = didx_reg;
            RES_REMOVED:   removed_next = best_val_reg;
            default:       status_next  = ST_OK;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            rv_reg    <= 1'b0;
            count_reg <= '0;
            cap_reg   <= CAP_RESET;
        end
        else
        begin
            idx_reg   <= idx_next;
            rv_reg    <= rd_issue;
            count_reg <= count_next;
            cap_reg   <= cap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_issue)
        begin
            rd_data_reg <= mem[idx_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= operation;
            val_reg <= value;
        end
        if (rd_issue)
        begin
            didx_reg <= idx_reg[ADDR_W-1:0];
        end
        // Keep the first occurrence of the maximum: replace only on strictly greater.
        if (cmd.scan && rv_reg && ((didx_reg == '0) || (rd_data_reg > best_val_reg)))
        begin
            best_idx_reg <= didx_reg;
            best_val_reg <= rd_data_reg;
        end
        if (cmd.finish)
        begin
            status           <= status_next;
            removed_value    <= removed_next;
            found_index      <= found_next;
            entry_count      <= count_next;
            logical_capacity <= cap_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/mrps_ctrl.sv
// Controller state machine: sequences decode, scan and shift passes and
// raises busy and the result strobe. Depends on mrps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrps_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    input  mrps_pkg::mrps_stat_t st,
    output mrps_pkg::mrps_cmd_t  cmd,
    output logic                 busy,
    output logic                 done
);
    import mrps_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;
    logic   done_reg, done_next;

    always_comb
    begin
        cmd        = '0;
        cmd.kind   = RES_NOP;
        state_next = state_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    busy_next   = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (st.op)
                    OP_ADD:
                    begin
                        cmd.finish = 1'b1;
                        cmd.kind   = st.full ? RES_FULL : RES_ADD;
                        state_next = S_DONE;
                    end
                    OP_REMOVE:
                    begin
                        if (st.empty)
                        begin
                            cmd.finish = 1'b1;
                            cmd.kind   = RES_EMPTY;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    OP_FIND:
                    begin
                        if (st.empty)
                        begin
                            cmd.finish = 1'b1;
                            cmd.kind   = RES_NOT_FOUND;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    default:
                    begin
                        cmd.finish = 1'b1;
                        cmd.kind   = RES_NOP;
                        state_next = S_DONE;
                    end
                endcase
                done_next = (state_next == S_DONE);
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (st.op == OP_FIND)
                begin
                    if (st.find_hit)
                    begin
                        cmd.finish = 1'b1;
                        cmd.kind   = RES_FOUND;
                        state_next = S_DONE;
                        done_next  = 1'b1;
                    end
                    else if (st.pass_done)
                    begin
                        cmd.finish = 1'b1;
                        cmd.kind   = RES_NOT_FOUND;
                        state_next = S_DONE;
                        done_next  = 1'b1;
                    end
                end
                else if (st.pass_done)
                begin
                    cmd.shift_init = 1'b1;
                    state_next     = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (st.pass_done)
                begin
                    cmd.finish = 1'b1;
                    cmd.kind   = RES_REMOVED;
                    state_next = S_DONE;
                    done_next  = 1'b1;
                end
            end
            S_DONE:
            begin
                busy_next  = 1'b0;
                state_next = S_IDLE;
            end
            default:
            begin
                busy_next  = 1'b0;
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

>>> sv/mrps_checker.sv
// Port-level checker for the max-removal priority store, bound to the top
// level. Depends on mrps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrps_checker (
    input wire                              clk,
    input wire                              rst_n,
    input wire                              start,
    input wire                              busy,
    input wire                              done,
    input wire [1:0]                        status,
    input wire [mrps_pkg::CNT_W-1:0]        entry_count,
    input wire [mrps_pkg::CAP_W-1:0]        logical_capacity
);
    import mrps_pkg::*;

    // A transaction taken in must hold off the next one.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after a transaction was accepted");

    a_done_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe outside a busy period");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_result_sane: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($onehot(logical_capacity) && (entry_count <= CNT_W'(DEPTH))
                  && ({1'b0, entry_count} <= logical_capacity)))
        else $error("count or capacity out of range in result");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_EMPTY)) |-> (entry_count == '0))
        else $error("empty status reported with entries stored");

endmodule

bind max_removal_priority_store_top mrps_checker u_mrps_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .done             (done),
    .status           (status),
    .entry_count      (entry_count),
    .logical_capacity (logical_capacity)
);

`default_nettype wire

>>> sim/max_removal_priority_store_top_tb.sv
// Testbench for max_removal_priority_store_top: directed and random add, remove and find
// transactions, each checked against a shadow copy of the store. Depends on mrps_pkg.
`timescale 1ns / 1ps

module max_removal_priority_store_top_tb;

    import mrps_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]       status;
        logic [VAL_W-1:0] removed;
        logic [ADDR_W-1:0] index;
        logic [CNT_W-1:0] count;
        logic [CAP_W-1:0] capacity;
    } store_result_t;

    // Shadow of the store: predicts each result and checks the block against it.
    class store_mirror;
        logic signed [VAL_W-1:0] slots [DEPTH];
        int fill;
        int cap;
        int errors;
        store_result_t awaited[$];

        function new();
            fill = 0;
            cap = 2;
            errors = 0;
        endfunction

        function store_result_t predict(logic [1:0] op, logic signed [VAL_W-1:0] val);
            store_result_t r;
            int best;
            int i;
            r = '0;
            r.status = ST_OK;
            case (op)
                OP_ADD:
                    if (fill >= DEPTH)
                        r.status = ST_FULL;
                    else
                    begin
                        if (fill == cap / 2)
                            cap = cap * 2;
                        slots[fill] = val;
                        fill++;
                    end
                OP_REMOVE:
                    if (fill == 0)
                        r.status = ST_EMPTY;
                    else
                    begin
                        best = 0;
                        // strict compare keeps the first occurrence on a tie
                        for (i = 1; i < fill; i++)
                            if (slots[i] > slots[best])
                                best = i;
                        r.removed = slots[best];
                        for (i = best + 1; i < fill; i++)
                            slots[i - 1] = slots[i];
                        fill--;
                        if (fill < cap / 4 && cap >= 4)
                            cap = cap / 2;
                    end
                OP_FIND:
                begin
                    r.status = ST_NOT_FOUND;
                    for (i = 0; i < fill; i++)
                        if (slots[i] == val)
                        begin
                            r.status = ST_OK;
                            r.index = ADDR_W'(i);
                            break;
                        end
                end
                default: ;
            endcase
            r.count = CNT_W'(fill);
            r.capacity = CAP_W'(cap);
            return r;
        endfunction

        function void note_item(logic [1:0] op, logic signed [VAL_W-1:0] val);
            awaited.push_back(predict(op, val));
        endfunction

        function void compare_field(string label, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
            end
        endfunction

        function void check_result(logic [1:0] st, logic [VAL_W-1:0] rem,
                                   logic [ADDR_W-1:0] idx, logic [CNT_W-1:0] cnt,
                                   logic [CAP_W-1:0] capacity);
            store_result_t w;
            if (awaited.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual status %h count %h",
                         $time, st, cnt);
                return;
            end
            w = awaited.pop_front();
            compare_field("status", 64'(w.status), 64'(st));
            compare_field("removed_value", 64'(w.removed), 64'(rem));
            compare_field("found_index", 64'(w.index), 64'(idx));
            compare_field("entry_count", 64'(w.count), 64'(cnt));
            compare_field("logical_capacity", 64'(w.capacity), 64'(capacity));
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic [1:0]              operation = OP_ADD;
    logic signed [VAL_W-1:0] value = '0;
    logic                    busy;
    logic                    done;
    logic [1:0]              status;
    logic signed [VAL_W-1:0] removed_value;
    logic [ADDR_W-1:0]       found_index;
    logic [CNT_W-1:0]        entry_count;
    logic [CAP_W-1:0]        logical_capacity;

    store_mirror mirror;
    bit          gaps_on;

    max_removal_priority_store_top dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .operation        (operation),
        .value            (value),
        .busy             (busy),
        .done             (done),
        .status           (status),
        .removed_value    (removed_value),
        .found_index      (found_index),
        .entry_count      (entry_count),
        .logical_capacity (logical_capacity)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
        if (rst_n && done)
            mirror.check_result(status, removed_value, found_index, entry_count,
                                logical_capacity);

    // Hold the transaction until it is taken; leave start high for back-to-back items.
    task automatic send_item(input logic [1:0] op, input logic signed [VAL_W-1:0] val);
        start <= 1'b1;
        operation <= op;
        value <= val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        mirror.note_item(op, val);
    endtask

    task automatic idle_gap();
        int roll;
        int gap;
        if (!gaps_on)
            return;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            gap = 0;
        else if (roll < 85)
            gap = $urandom_range(1, 3);
        else if (roll < 97)
            gap = $urandom_range(4, 12);
        else
            gap = $urandom_range(20, 60);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (mirror.awaited.size() != 0)
            @(posedge clk);
    endtask

    // Half of the values come from a narrow pool so that ties and find hits are common.
    function automatic logic signed [VAL_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 5)
            return VAL_W'($signed($urandom_range(0, 7)) - 3);
        if (roll == 5)
            case ($urandom_range(0, 3))
                0: return {1'b0, {(VAL_W-1){1'b1}}};
                1: return {1'b1, {(VAL_W-1){1'b0}}};
                2: return '0;
                default: return '1;
            endcase
        return $urandom;
    endfunction

    task automatic run_phase(input int items, input int add_pct, input int remove_pct);
        int done_items;
        int roll;
        logic signed [VAL_W-1:0] v;
        done_items = 0;
        while (done_items < items)
        begin
            roll = $urandom_range(0, 99);
            if (roll < add_pct)
                send_item(OP_ADD, pick_value());
            else if (roll < add_pct + remove_pct)
                send_item(OP_REMOVE, $urandom);
            else if (roll < 98)
            begin
                if (mirror.fill > 0 && $urandom_range(0, 9) < 6)
                    v = mirror.slots[$urandom_range(0, mirror.fill - 1)];
                else
                    v = pick_value();
                send_item(OP_FIND, v);
            end
            else
            begin
                // ignored code: not counted
                send_item(OP_UNUSED, $urandom);
                done_items--;
            end
            done_items++;
            idle_gap();
        end
    endtask

    initial
    begin
        mirror = new();
        gaps_on = 1'b1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(OP_REMOVE, 32'h0000_0000);
        send_item(OP_FIND, 32'h0000_0000);
        send_item(OP_UNUSED, 32'h5A5A_5A5A);
        send_item(OP_ADD, 32'h7FFF_FFFF);
        send_item(OP_ADD, 32'h8000_0000);
        idle_gap();
        send_item(OP_ADD, 32'h0000_0000);
        send_item(OP_ADD, 32'hFFFF_FFFF);
        send_item(OP_ADD, 32'h7FFF_FFFF);
        send_item(OP_FIND, 32'h8000_0000);
        send_item(OP_FIND, 32'hFFFF_FFFF);
        idle_gap();
        send_item(OP_FIND, 32'h7FFF_FFFF);
        send_item(OP_FIND, 32'h1234_5678);
        send_item(OP_UNUSED, 32'hFFFF_FFFF);
        send_item(OP_REMOVE, 32'hFFFF_FFFF);
        send_item(OP_REMOVE, 32'h0000_0000);
        idle_gap();
        send_item(OP_REMOVE, 32'h0000_0000);
        send_item(OP_REMOVE, 32'h0000_0000);
        send_item(OP_REMOVE, 32'h0000_0000);
        send_item(OP_REMOVE, 32'h0000_0000);
        send_item(OP_ADD, -32'sd5);
        send_item(OP_ADD, -32'sd5);
        send_item(OP_FIND, -32'sd5);
        send_item(OP_REMOVE, 32'h0000_0000);
        wait_drained();

        // fill to full and hammer it, mixed traffic, drain to empty, fill and drain again, then mixed traffic
        run_phase(95, 85, 5);
        wait_drained();
        gaps_on = 1'b0;
        run_phase(80, 40, 35);
        gaps_on = 1'b1;
        run_phase(95, 8, 80);
        wait_drained();
        run_phase(95, 85, 5);
        gaps_on = 1'b0;
        run_phase(95, 8, 80);
        gaps_on = 1'b1;
        run_phase(90, 45, 30);

        wait_drained();
        repeat (20) @(posedge clk);
        if (mirror.errors == 0)
            $display("max_removal_priority_store_top_tb: done, clean");
        else
            $display("max_removal_priority_store_top_tb: done, errors");
        $finish;
    end

    initial
    begin
        #9_000_000;
        $display("%0t: timeout", $time);
        $display("max_removal_priority_store_top_tb: done, errors");
        $finish;
    end

endmodule

>>> filelist.f
sv/mrps_pkg.sv
sv/mrps_datapath.sv
sv/mrps_ctrl.sv
sv/max_removal_priority_store_top.sv
sv/mrps_checker.sv
sim/max_removal_priority_store_top_tb.sv
